// File: hdl/ire_pkg.sv
// Shared types, constants and helper functions of the IR remote pulse encoder.
package ire_pkg;

	// Mode register codes.
	localparam logic [2:0] MODE_NOISE = 3'd0;
	localparam logic [2:0] MODE_RAW   = 3'd1;
	localparam logic [2:0] MODE_TABLE = 3'd2;
	localparam logic [2:0] MODE_NEC   = 3'd3;
	localparam logic [2:0] MODE_WIDE  = 3'd4;
	localparam logic [2:0] MODE_SIRC  = 3'd5;

	// Pulse lengths in carrier cycles.
	localparam logic [8:0] HDR_MARK   = 9'd342;
	localparam logic [7:0] HDR_SPACE  = 8'd171;
	localparam logic [8:0] WIDE_MARK  = 9'd171;
	localparam logic [8:0] BIT_MARK   = 9'd21;
	localparam logic [7:0] ONE_SPACE  = 8'd64;
	localparam logic [7:0] ZERO_SPACE = 8'd21;
	localparam logic [7:0] STOP_SPACE = 8'd0;
	localparam logic [8:0] SIRC_HDR   = 9'd91;
	localparam logic [8:0] SIRC_ONE   = 9'd46;
	localparam logic [8:0] SIRC_UNIT  = 9'd23;
	localparam logic [7:0] SIRC_SPACE = 8'd23;
	localparam logic [8:0] RAW_MARK   = 9'd10;
	localparam logic [7:0] RAW_SPACE  = 8'd10;

	// Index of the final pair for each frame kind.
	localparam logic [5:0] NOISE_LAST = 6'd49;
	localparam logic [5:0] RAW_LAST   = 6'd31;
	localparam logic [5:0] NEC_LAST   = 6'd33;
	localparam logic [5:0] SIRC_LAST  = 6'd12;

	typedef enum logic [2:0] {
		KIND_NOISE,
		KIND_RAW,
		KIND_NEC,
		KIND_WIDE,
		KIND_SIRC
	} frame_kind_t;

	typedef struct packed {
		frame_kind_t kind;
		logic [31:0] word;
	} frame_desc_t;

	localparam int DESC_W = $bits(frame_desc_t);

	function automatic logic [31:0] xs_round(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction

	function automatic logic [31:0] code_rom(input logic [3:0] idx);
		logic [31:0] c;
		case (idx)
			4'd0:    c = 32'h20DF10EF;
			4'd1:    c = 32'hE0E040BF;
			4'd2:    c = 32'hA8B415EA;
			4'd3:    c = 32'h02FD48B7;
			4'd4:    c = 32'h00FF02FD;
			4'd5:    c = 32'h40BF18E7;
			4'd6:    c = 32'h4CB340BF;
			4'd7:    c = 32'h0000480B;
			4'd8:    c = 32'h02FD18E7;
			4'd9:    c = 32'hCF336B94;
			4'd10:   c = 32'hAA559966;
			4'd11:   c = 32'h08F748B7;
			default: c = 32'h0;
		endcase
		return c;
	endfunction

endpackage

// File: hdl/ire_seed_if.sv
// Trigger channel carrying one 32-bit seed per frame.
interface ire_seed_if;
	logic        valid;
	logic        ready;
	logic [31:0] seed;

	modport source (output valid, output seed, input ready);
	modport sink (input valid, input seed, output ready);
endinterface

// File: hdl/ire_pair_if.sv
// Output channel carrying one mark/space pair per transfer.
interface ire_pair_if;
	logic       valid;
	logic       ready;
	logic [8:0] mark_ticks;
	logic [7:0] space_ticks;
	logic       last;

	modport source (output valid, output mark_ticks, output space_ticks, output last,
		input ready);
	modport sink (input valid, input mark_ticks, input space_ticks, input last,
		output ready);
endinterface

// File: hdl/ire_front.sv
// Front end: takes triggers, scrambles the seed and builds a frame descriptor.
module ire_front #(
	parameter int TABLE_ENTRIES = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	ire_seed_if.sink            trigger,
	input  logic [2:0]          mode,
	input  logic                queue_full,
	output logic                push,
	output ire_pkg::frame_desc_t desc
);
	import ire_pkg::*;

	logic [3:0]  table_index_q;
	logic [4:0]  idx_inc;
	logic [31:0] r;

	assign trigger.ready = !queue_full;
	assign push          = trigger.valid && !queue_full;
	assign r             = xs_round(trigger.seed);
	assign idx_inc       = {1'b0, table_index_q} + 5'd1;

	always_comb begin
		desc.word = r;
		case (mode)
			MODE_RAW: desc.kind = KIND_RAW;
			MODE_TABLE: begin
				desc.kind = KIND_NEC;
				desc.word = code_rom(table_index_q);
			end
			MODE_NEC:  desc.kind = KIND_NEC;
			MODE_WIDE: desc.kind = KIND_WIDE;
			MODE_SIRC: desc.kind = KIND_SIRC;
			default:   desc.kind = KIND_NOISE;
		endcase
	end

	// The table index only moves on frames taken in table mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_index_q <= 4'd0;
		end else if (push && mode == MODE_TABLE) begin
			if (idx_inc >= 5'(TABLE_ENTRIES)) begin
				table_index_q <= 4'd0;
			end else begin
				table_index_q <= idx_inc[3:0];
			end
		end
	end

endmodule

// File: hdl/ire_queue.sv
// Small descriptor queue between the front end and the pulse sequencer.
module ire_queue #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: hdl/ire_back.sv
// Back end: walks one frame descriptor and emits its mark/space pairs.
module ire_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                queue_empty,
	input  ire_pkg::frame_desc_t desc,
	output logic                pop,
	ire_pair_if.source          pairs
);
	import ire_pkg::*;

	frame_kind_t kind_q;
	logic [31:0] word_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        out_valid_q;
	logic [8:0]  mark_q;
	logic [7:0]  space_q;
	logic        last_q;

	logic        advance;
	logic [8:0]  mark_n;
	logic [7:0]  space_n;
	logic        last_n;
	logic [31:0] word_n;
	logic [31:0] r1;
	logic [31:0] r2;

	assign pop     = !busy_q && !queue_empty;
	assign advance = busy_q && (!out_valid_q || pairs.ready);
	assign r1      = xs_round(word_q);
	assign r2      = xs_round(r1);

	always_comb begin
		mark_n  = RAW_MARK;
		space_n = RAW_SPACE;
		last_n  = 1'b0;
		word_n  = word_q;
		case (kind_q)
			KIND_RAW: begin
				// Two generator rounds per pair: one for the mark, one for the space.
				mark_n  = RAW_MARK + {3'b000, r1[5:0]};
				space_n = RAW_SPACE + {2'b00, r2[5:0]};
				last_n  = cnt_q == RAW_LAST;
				word_n  = r2;
			end
			KIND_NEC, KIND_WIDE: begin
				if (cnt_q == 6'd0) begin
					mark_n  = (kind_q == KIND_WIDE) ? WIDE_MARK : HDR_MARK;
					space_n = HDR_SPACE;
				end else if (cnt_q == NEC_LAST) begin
					mark_n  = BIT_MARK;
					space_n = STOP_SPACE;
					last_n  = 1'b1;
				end else begin
					mark_n  = BIT_MARK;
					space_n = word_q[31] ? ONE_SPACE : ZERO_SPACE;
					word_n  = {word_q[30:0], 1'b0};
				end
			end
			KIND_SIRC: begin
				if (cnt_q == 6'd0) begin
					mark_n  = SIRC_HDR;
					space_n = SIRC_SPACE;
				end else begin
					mark_n  = word_q[0] ? SIRC_ONE : SIRC_UNIT;
					space_n = SIRC_SPACE;
					last_n  = cnt_q == SIRC_LAST;
					word_n  = {1'b0, word_q[31:1]};
				end
			end
			default: begin
				last_n = cnt_q == NOISE_LAST;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= 6'd0;
			kind_q      <= KIND_NOISE;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				kind_q <= desc.kind;
				cnt_q  <= 6'd0;
			end else if (advance) begin
				cnt_q <= cnt_q + 6'd1;
				if (last_n) begin
					busy_q <= 1'b0;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pairs.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= desc.word;
		end else if (advance) begin
			word_q <= word_n;
		end
		if (advance) begin
			mark_q  <= mark_n;
			space_q <= space_n;
			last_q  <= last_n;
		end
	end

	assign pairs.valid       = out_valid_q;
	assign pairs.mark_ticks  = mark_q;
	assign pairs.space_ticks = space_q;
	assign pairs.last        = last_q;

endmodule

// File: hdl/ir_remote_pulse_encoder.sv
// Top level of the IR remote pulse encoder: register port, front end, queue, sequencer.
//
// Each transfer on the trigger channel carries a 32-bit seed and starts one frame.
// The frame goes out on the pairs channel as mark/space pairs counted in carrier
// cycles, one pair per transfer, with last set on the final pair. The mode register
// (byte address 0) picks the frame type and should only be written while idle.
// Frame lengths: noise 50 pairs, random raw 32, NEC variants 34, SIRC 13.
// A trigger is taken whenever the two-entry descriptor queue has room,
// so triggers are accepted while an earlier frame is still being sent.
// With the sequencer free, a trigger's descriptor passes through the queue and the
// sequencer registers before its first pair is registered; pairs then follow one
// per cycle while the sink is ready, and no pair goes out while the
// sequencer loads the next descriptor from the queue.
// When the sink stalls, the pair register holds and the sequencer waits; triggers
// keep being taken until the queue fills.
// Reset clears the mode to noise, the code table index to zero and empties the queue.
module ir_remote_pulse_encoder #(
	parameter int TABLE_ENTRIES = 12,
	parameter int QUEUE_DEPTH   = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	ire_seed_if.sink    trigger,
	ire_pair_if.source  pairs
);
	import ire_pkg::*;

	logic [2:0]  mode_q;
	logic        queue_full;
	logic        queue_empty;
	logic        push;
	logic        pop;
	frame_desc_t push_desc;
	frame_desc_t pop_desc;
	logic [DESC_W-1:0] pop_bits;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {29'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NOISE;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			mode_q <= pwdata[2:0];
		end
	end

	ire_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.trigger    (trigger),
		.mode       (mode_q),
		.queue_full (queue_full),
		.push       (push),
		.desc       (push_desc)
	);

	ire_queue #(
		.WIDTH(DESC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_desc),
		.pop    (pop),
		.rdata  (pop_bits),
		.full   (queue_full),
		.empty  (queue_empty)
	);

	assign pop_desc = frame_desc_t'(pop_bits);

	ire_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.desc        (pop_desc),
		.pop         (pop),
		.pairs       (pairs)
	);

endmodule

// File: hdl/ire_checker.sv
// Port-level checks of the IR remote pulse encoder and their bind to the top level.
module ire_checker (
	input logic        clk,
	input logic        arst_n,
	input logic [31:0] prdata,
	input logic        out_valid,
	input logic        out_ready,
	input logic [8:0]  mark_ticks,
	input logic [7:0]  space_ticks,
	input logic        last
);

	// A stalled pair must not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mark_ticks)
			&& $stable(space_ticks) && $stable(last))
		else $error("pair changed while stalled");

	// Only the stop pair has an empty space, and it always closes the frame.
	a_stop_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && space_ticks == 8'd0 |-> last)
		else $error("zero space on a pair that is not last");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mark_ticks <= 9'd342 && space_ticks <= 8'd171)
		else $error("pair length out of range");

	a_prdata: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[31:3] == 29'd0)
		else $error("read data has bits above the mode field");

endmodule

bind ir_remote_pulse_encoder ire_checker u_ire_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.prdata      (prdata),
	.out_valid   (pairs.valid),
	.out_ready   (pairs.ready),
	.mark_ticks  (pairs.mark_ticks),
	.space_ticks (pairs.space_ticks),
	.last        (pairs.last)
);
